@@ rtl/core/ade_pkg.sv @@
`timescale 1ns / 1ps
// Package for the attack/decay envelope block: widths, constants, microcode
// opcodes, the microcode table and the control structs. No dependencies.
package ade_pkg;

	localparam int TIME_BITS = 32;
	localparam int Q_BITS    = 16;
	localparam int CNT_BITS  = $clog2(Q_BITS + 1);
	localparam int ENV_BITS  = Q_BITS + 1;
	localparam int PEAK_BITS = 16;
	localparam int SCALE_BITS = 13;
	localparam int PK_BITS   = PEAK_BITS + SCALE_BITS;
	localparam int PROD_BITS = PK_BITS + ENV_BITS;
	localparam int BLUR_SHIFT = 31;
	localparam int BLUR_BITS = 13;
	localparam int STEP_BITS = 4;

	localparam logic [47:0] TIME_MAX = (48'd1 << TIME_BITS) - 48'd1;
	localparam logic [PEAK_BITS-1:0] PEAK_ONE = 16'h8000;
	localparam logic [SCALE_BITS-1:0] SCALE_Q16 = 13'd5243;
	localparam logic [ENV_BITS-1:0] ENV_ONE = 17'h10000;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE    = 4'd0;
	localparam op_t OP_LATCH   = 4'd1;
	localparam op_t OP_START   = 4'd2;
	localparam op_t OP_TICK    = 4'd3;
	localparam op_t OP_DIVLOAD = 4'd4;
	localparam op_t OP_DIVSTEP = 4'd5;
	localparam op_t OP_ENV     = 4'd6;
	localparam op_t OP_MULPK   = 4'd7;
	localparam op_t OP_MULENV  = 4'd8;
	localparam op_t OP_OUT     = 4'd9;

	typedef logic [2:0] cond_t;
	localparam cond_t COND_NEVER    = 3'd0;
	localparam cond_t COND_ALWAYS   = 3'd1;
	localparam cond_t COND_NO_IN    = 3'd2;
	localparam cond_t COND_IS_TICK  = 3'd3;
	localparam cond_t COND_NO_ENV   = 3'd4;
	localparam cond_t COND_DIV_MORE = 3'd5;
	localparam cond_t COND_OUT_BUSY = 3'd6;

	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t ST_WAIT     = 4'd0;
	localparam step_t ST_DISPATCH = 4'd1;
	localparam step_t ST_START    = 4'd2;
	localparam step_t ST_TICK     = 4'd3;
	localparam step_t ST_DIVLOAD  = 4'd4;
	localparam step_t ST_DIVSTEP  = 4'd5;
	localparam step_t ST_ENV      = 4'd6;
	localparam step_t ST_MULPK    = 4'd7;
	localparam step_t ST_MULENV   = 4'd8;
	localparam step_t ST_OUT      = 4'd9;
	localparam step_t ST_BACK     = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic is_tick;
		logic no_env;
		logic div_more;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{op: OP_NONE, cond: COND_ALWAYS, target: ST_WAIT};
		unique case (step)
			ST_WAIT:     w = '{op: OP_LATCH,   cond: COND_NO_IN,    target: ST_WAIT};
			ST_DISPATCH: w = '{op: OP_NONE,    cond: COND_IS_TICK,  target: ST_TICK};
			ST_START:    w = '{op: OP_START,   cond: COND_ALWAYS,   target: ST_OUT};
			ST_TICK:     w = '{op: OP_TICK,    cond: COND_NO_ENV,   target: ST_OUT};
			ST_DIVLOAD:  w = '{op: OP_DIVLOAD, cond: COND_NEVER,    target: ST_WAIT};
			ST_DIVSTEP:  w = '{op: OP_DIVSTEP, cond: COND_DIV_MORE, target: ST_DIVSTEP};
			ST_ENV:      w = '{op: OP_ENV,     cond: COND_NEVER,    target: ST_WAIT};
			ST_MULPK:    w = '{op: OP_MULPK,   cond: COND_NEVER,    target: ST_WAIT};
			ST_MULENV:   w = '{op: OP_MULENV,  cond: COND_NEVER,    target: ST_WAIT};
			ST_OUT:      w = '{op: OP_OUT,     cond: COND_OUT_BUSY, target: ST_OUT};
			ST_BACK:     w = '{op: OP_NONE,    cond: COND_ALWAYS,   target: ST_WAIT};
			default:     w = '{op: OP_NONE,    cond: COND_ALWAYS,   target: ST_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_time(input logic [31:0] v);
		logic [47:0] w;
		w = 48'(v);
		return (w > TIME_MAX) ? TIME_BITS'(TIME_MAX) : TIME_BITS'(w);
	endfunction

endpackage

@@ rtl/core/ade_sequencer.sv @@
`timescale 1ns / 1ps
// Microcode sequencer: step counter, microcode table lookup and jump logic.
// Depends on ade_pkg for the table, opcodes and control structs.
module ade_sequencer import ade_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t  pc_q;
	uword_t uw;
	logic   take;

	assign uw = ucode(pc_q);
	assign ctrl.op = uw.op;

	always_comb begin
		unique case (uw.cond)
			COND_NEVER:    take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_IN:    take = !stat.in_fire;
			COND_IS_TICK:  take = stat.is_tick;
			COND_NO_ENV:   take = stat.no_env;
			COND_DIV_MORE: take = stat.div_more;
			COND_OUT_BUSY: take = stat.out_busy;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else begin
			pc_q <= take ? uw.target : step_t'(pc_q + 1'b1);
		end
	end

endmodule

@@ rtl/core/attack_decay_envelope.sv @@
`timescale 1ns / 1ps
// Top level of the attack/decay envelope generator: envelope state, divider,
// multipliers and output register. Depends on ade_pkg and ade_sequencer.
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_data (enabled bit)
// in       in         in_valid / in_ready    kind, peak_request, attack_us,
//                                            duration_us, delta_us
// out      out        out_valid / out_ready  accepted, active, draw, blur_strength
//
// A start transaction, or a tick that finds no running envelope or ends it, goes through
// dispatch, start or tick, output and return steps before the next input is taken; a tick
// that keeps it running adds divider load, 16-step serial divider, envelope, multiplies.
// The output register lets a finished result wait while the next input is taken.
// Reset clears the envelope state, the enable bit and the sequencer.
// A stalled output holds the sequencer at its output step.
module attack_decay_envelope import ade_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [15:0]          peak_request,
	input  logic [31:0]          attack_us,
	input  logic [31:0]          duration_us,
	input  logic [31:0]          delta_us,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic                 active,
	output logic                 draw,
	output logic [BLUR_BITS-1:0] blur_strength
);

	stat_t stat;
	ctrl_t ctrl;

	logic                 enabled_q;
	logic [PEAK_BITS-1:0] peak_level_q;
	logic [TIME_BITS-1:0] attack_len_q;
	logic [TIME_BITS-1:0] total_len_q;
	logic [TIME_BITS-1:0] elapsed_q;

	logic                 kind_q;
	logic [PEAK_BITS-1:0] req_q;
	logic [TIME_BITS-1:0] atk_q;
	logic [TIME_BITS-1:0] dur_q;
	logic [TIME_BITS-1:0] dt_q;

	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] den_q;
	logic [Q_BITS-1:0]    quo_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 phase_atk_q;
	logic [ENV_BITS-1:0]  env_q;
	logic [PK_BITS-1:0]   pk_q;

	logic                 res_accepted_q;
	logic                 res_draw_q;
	logic [BLUR_BITS-1:0] res_blur_q;

	logic                 out_valid_q;
	logic                 out_accepted_q;
	logic                 out_active_q;
	logic                 out_draw_q;
	logic [BLUR_BITS-1:0] out_blur_q;

	logic                 in_fire;
	logic                 start_ok;
	logic                 tick_live;
	logic [TIME_BITS:0]   sum;
	logic                 tick_runs;
	logic [TIME_BITS:0]   rem_sh;
	logic                 rem_ge;
	logic [2*Q_BITS-1:0]  sq;
	logic [PROD_BITS-1:0] prod;
	logic [BLUR_BITS-1:0] blur;

	ade_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (ctrl.op == OP_LATCH);
	assign in_fire   = in_valid && in_ready;

	assign start_ok = enabled_q && (req_q != '0) && (dur_q != '0)
		&& !((total_len_q != '0) && (peak_level_q > req_q));
	assign tick_live = enabled_q && (total_len_q != '0);
	assign sum       = {1'b0, elapsed_q} + {1'b0, dt_q};
	assign tick_runs = tick_live && (sum < {1'b0, total_len_q});

	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});
	assign sq     = quo_q * quo_q;
	assign prod   = PROD_BITS'(pk_q) * PROD_BITS'(env_q);
	assign blur   = prod[BLUR_SHIFT +: BLUR_BITS];

	assign stat.in_fire  = in_fire;
	assign stat.is_tick  = kind_q;
	assign stat.no_env   = !tick_runs;
	assign stat.div_more = (cnt_q != CNT_BITS'(1));
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			peak_level_q <= '0;
			attack_len_q <= '0;
			total_len_q  <= '0;
			elapsed_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enabled_q <= cfg_data;
			end
			if (ctrl.op == OP_START && start_ok) begin
				peak_level_q <= (req_q > PEAK_ONE) ? PEAK_ONE : req_q;
				attack_len_q <= (atk_q < dur_q) ? atk_q : dur_q;
				total_len_q  <= dur_q;
				elapsed_q    <= '0;
			end
			if (ctrl.op == OP_TICK && tick_live) begin
				if (tick_runs) begin
					elapsed_q <= TIME_BITS'(sum);
				end else begin
					elapsed_q   <= '0;
					total_len_q <= '0;
				end
			end
			if (ctrl.op == OP_OUT && !stat.out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q         <= kind;
			req_q          <= peak_request;
			atk_q          <= sat_time(attack_us);
			dur_q          <= sat_time(duration_us);
			dt_q           <= sat_time(delta_us);
			res_accepted_q <= 1'b0;
			res_draw_q     <= 1'b0;
			res_blur_q     <= '0;
		end
		if (ctrl.op == OP_START) begin
			res_accepted_q <= start_ok;
		end
		if (ctrl.op == OP_DIVLOAD) begin
			phase_atk_q <= (elapsed_q < attack_len_q);
			if (elapsed_q < attack_len_q) begin
				rem_q <= elapsed_q;
				den_q <= attack_len_q;
			end else begin
				rem_q <= elapsed_q - attack_len_q;
				den_q <= total_len_q - attack_len_q;
			end
			quo_q <= '0;
			cnt_q <= CNT_BITS'(Q_BITS);
		end
		if (ctrl.op == OP_DIVSTEP) begin
			rem_q <= rem_ge ? TIME_BITS'(rem_sh - {1'b0, den_q}) : TIME_BITS'(rem_sh);
			quo_q <= {quo_q[Q_BITS-2:0], rem_ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (ctrl.op == OP_ENV) begin
			env_q <= phase_atk_q ? ENV_BITS'(sq[2*Q_BITS-1:Q_BITS])
				: ENV_ONE - ENV_BITS'(quo_q);
		end
		if (ctrl.op == OP_MULPK) begin
			pk_q <= PK_BITS'(peak_level_q) * PK_BITS'(SCALE_Q16);
		end
		if (ctrl.op == OP_MULENV) begin
			res_blur_q <= blur;
			res_draw_q <= (blur != '0);
		end
		if (ctrl.op == OP_OUT && !stat.out_busy) begin
			out_accepted_q <= res_accepted_q;
			out_active_q   <= (total_len_q != '0);
			out_draw_q     <= res_draw_q;
			out_blur_q     <= res_blur_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = out_accepted_q;
	assign active        = out_active_q;
	assign draw          = out_draw_q;
	assign blur_strength = out_blur_q;

`ifndef ASSERT_OFF
	a_elapsed_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(total_len_q != '0) |-> (elapsed_q < total_len_q))
		else $error("Elapsed time reached the duration while the envelope is active.");

	a_attack_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		attack_len_q <= total_len_q || total_len_q == '0)
		else $error("Attack time exceeds the duration.");

	a_peak_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		peak_level_q <= PEAK_ONE)
		else $error("Stored peak exceeds one.");

	a_draw_matches_blur: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_draw_q == (out_blur_q != '0)))
		else $error("Draw flag disagrees with blur strength.");

	a_start_no_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_accepted_q) |-> !out_draw_q)
		else $error("A start result reports a draw.");
`endif

endmodule

@@ verif/attack_decay_envelope_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for attack_decay_envelope: a directed table, then random envelope
// sequences under three idling profiles, checked against a built-in envelope predictor.
// Depends on ade_pkg and the attack_decay_envelope RTL.
module attack_decay_envelope_tb;
	import ade_pkg::*;

	localparam bit KIND_START = 1'b0;
	localparam bit KIND_TICK = 1'b1;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SEGMENT_ITEMS = 55;

	typedef struct packed {
		logic                 accepted;
		logic                 active;
		logic                 draw;
		logic [BLUR_BITS-1:0] blur;
	} response_t;

	typedef struct packed {
		bit        en;
		bit        knd;
		logic [15:0] peak;
		logic [31:0] atk;
		logic [31:0] dur;
		logic [31:0] dt;
		bit        known;
		response_t want;
	} stim_row_t;

	localparam response_t RESP_IDLE = '0;
	localparam response_t RESP_HELD = {3'b010, 13'd0};
	localparam response_t RESP_ARMED = {3'b110, 13'd0};
	localparam response_t RESP_FULL = {3'b011, 13'd5243};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = 1'b0;
	logic [15:0]          peak_request = '0;
	logic [31:0]          attack_us = '0;
	logic [31:0]          duration_us = '0;
	logic [31:0]          delta_us = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 accepted;
	logic                 active;
	logic                 draw;
	logic [BLUR_BITS-1:0] blur_strength;

	bit                   env_enabled;
	logic [15:0]          env_peak;
	logic [TIME_BITS-1:0] env_attack;
	logic [TIME_BITS-1:0] env_total;
	logic [TIME_BITS-1:0] env_elapsed;

	response_t            pending_responses[$];
	response_t            head;
	stim_row_t            directed[$];
	int unsigned          mismatches = 0;
	int unsigned          item_count = 0;
	int                   send_idle = 27;
	int                   recv_idle = 59;
	int unsigned          hold_off_asks = 0;
	int unsigned          hold_off_seen = 0;
	int unsigned          stall_left = 0;

	attack_decay_envelope dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.peak_request(peak_request),
		.attack_us(attack_us),
		.duration_us(duration_us),
		.delta_us(delta_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.active(active),
		.draw(draw),
		.blur_strength(blur_strength)
	);

	always #4 clk = ~clk;

	function automatic response_t step_envelope(input bit knd, input logic [15:0] req,
			input logic [31:0] atk, input logic [31:0] dur, input logic [31:0] dt);
		response_t        r;
		longint unsigned  sum;
		longint unsigned  t;
		longint unsigned  env;
		longint unsigned  blur;
		r = '0;
		if (knd == KIND_START) begin
			if (env_enabled && req != 0 && dur != 0 && !(env_total != 0 && env_peak > req)) begin
				env_peak = (req > PEAK_ONE) ? PEAK_ONE : req;
				env_attack = (atk < dur) ? atk : dur;
				env_total = dur;
				env_elapsed = '0;
				r.accepted = 1'b1;
			end
		end else if (env_enabled && env_total != 0) begin
			sum = 64'(env_elapsed) + 64'(dt);
			if (sum >= 64'(env_total)) begin
				env_total = '0;
				env_elapsed = '0;
			end else begin
				env_elapsed = sum[TIME_BITS-1:0];
				if (env_elapsed < env_attack) begin
					t = (64'(env_elapsed) << 16) / 64'(env_attack);
					env = (t * t) >> 16;
				end else begin
					t = (64'(env_elapsed - env_attack) << 16) / 64'(env_total - env_attack);
					env = (t >= 65536) ? 0 : 65536 - t;
				end
				blur = (64'(SCALE_Q16) * 64'(env_peak) * env) >> BLUR_SHIFT;
				r.blur = blur[BLUR_BITS-1:0];
				r.draw = (blur != 0);
			end
		end
		r.active = (env_total != 0);
		return r;
	endfunction

	function automatic stim_row_t row(input bit en, input bit knd, input logic [15:0] pk,
			input logic [31:0] at, input logic [31:0] du, input logic [31:0] dl,
			input bit known, input response_t want);
		stim_row_t s;
		s = {en, knd, pk, at, du, dl, known, want};
		return s;
	endfunction

	function automatic logic [31:0] rand_time();
		int unsigned w;
		w = $urandom_range(1, 32);
		return $urandom >> (32 - w);
	endfunction

	task automatic offer(input bit knd, input logic [15:0] pk, input logic [31:0] at,
			input logic [31:0] du, input logic [31:0] dl, input bit known, input response_t want);
		int        gap;
		response_t got;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle && gap < 40)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= knd;
		peak_request <= pk;
		attack_us <= at;
		duration_us <= du;
		delta_us <= dl;
		do @(posedge clk); while (!in_ready);
		got = step_envelope(knd, pk, at, du, dl);
		pending_responses.push_back(known ? want : got);
		item_count++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input bit value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		env_enabled = value;
	endtask

	task automatic random_sequence();
		int              n;
		logic [15:0]     pk;
		logic [31:0]     atk;
		logic [31:0]     dur;
		longint unsigned span;
		longint unsigned hi;
		if ($urandom_range(0, 99) < 25) begin
			if ($urandom_range(0, 1) != 0)
				offer(1'($urandom_range(0, 1)), 16'($urandom), $urandom, $urandom, $urandom,
					PREDICTED, RESP_IDLE);
			else
				offer(1'($urandom_range(0, 1)), 16'($urandom), rand_time(), rand_time(),
					rand_time(), PREDICTED, RESP_IDLE);
			return;
		end
		case ($urandom_range(0, 3))
			0: pk = 16'($urandom);
			1: pk = 16'($urandom_range(1, 32768));
			2: pk = 16'($urandom_range(32768, 65535));
			default: pk = 16'($urandom_range(1, 255));
		endcase
		dur = rand_time();
		case ($urandom_range(0, 3))
			0: atk = 32'd0;
			1: atk = rand_time();
			default: atk = $urandom_range(0, dur);
		endcase
		offer(KIND_START, pk, atk, dur, $urandom, PREDICTED, RESP_IDLE);
		n = $urandom_range(1, 12);
		span = 64'(dur) / 64'(n);
		hi = 2 * span + 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				offer(KIND_START, 16'($urandom), rand_time(), rand_time(), $urandom,
					PREDICTED, RESP_IDLE);
			else
				offer(KIND_TICK, 16'($urandom), $urandom, $urandom,
					$urandom_range(0, hi[31:0]), PREDICTED, RESP_IDLE);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (hold_off_seen != hold_off_asks) begin
			hold_off_seen <= hold_off_asks;
			stall_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				$error("result transaction with no expected result");
				mismatches++;
			end else begin
				head = pending_responses.pop_front();
				if (accepted !== head.accepted) begin
					$error("accepted: expected %0d, actual %0d", head.accepted, accepted);
					mismatches++;
				end
				if (active !== head.active) begin
					$error("active: expected %0d, actual %0d", head.active, active);
					mismatches++;
				end
				if (draw !== head.draw) begin
					$error("draw: expected %0d, actual %0d", head.draw, draw);
					mismatches++;
				end
				if (blur_strength !== head.blur) begin
					$error("blur_strength: expected %0d, actual %0d", head.blur, blur_strength);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("attack_decay_envelope: mismatch");
		$finish;
	end

	initial begin
		int          ph;
		int          seg;
		int unsigned seg_end;
		env_enabled = 1'b0;
		env_peak = '0;
		env_attack = '0;
		env_total = '0;
		env_elapsed = '0;

		directed.push_back(row(0, KIND_START, 16'h8000, 32'd100, 32'd1000, 32'd0, TYPED, RESP_IDLE));
		directed.push_back(row(0, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd10, TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd5, TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'd0, 32'd10, 32'd1000, 32'd0, TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'd100, 32'd10, 32'd0, 32'd0, TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0,
			TYPED, RESP_ARMED));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, TYPED, RESP_FULL));
		directed.push_back(row(1, KIND_START, 16'd1, 32'd0, 32'd1000, 32'd0, TYPED, RESP_HELD));
		directed.push_back(row(1, KIND_START, 16'h8000, 32'hFFFF_FFFF, 32'd1000, 32'd0,
			TYPED, RESP_ARMED));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd500, PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd499, PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd1, TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'h8001, 32'd0, 32'hFFFF_FFFF, 32'd0,
			TYPED, RESP_ARMED));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
			TYPED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'd1, 32'd1, 32'd2, 32'd0, TYPED, RESP_ARMED));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd1, PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'd2, 32'd3, 32'd10, 32'd0, PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'd1000, 32'd100, 32'd0, 32'd0,
			PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd0, PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFE,
			PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_START, 16'h4000, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
			PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
			PREDICTED, RESP_IDLE));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'h4000_0000,
			PREDICTED, RESP_IDLE));
		directed.push_back(row(0, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'd1, TYPED, RESP_HELD));
		directed.push_back(row(0, KIND_START, 16'hFFFF, 32'd5, 32'd50, 32'd0, TYPED, RESP_HELD));
		directed.push_back(row(1, KIND_TICK, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
			TYPED, RESP_IDLE));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].en != env_enabled) begin
				settle();
				write_enable(directed[i].en);
			end
			offer(directed[i].knd, directed[i].peak, directed[i].atk, directed[i].dur,
				directed[i].dt, directed[i].known, directed[i].want);
		end

		for (ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 27 : (ph == 1) ? 59 : 0;
			recv_idle = (ph == 0) ? 59 : (ph == 1) ? 27 : 0;
			for (seg = 0; seg < 7; seg++) begin
				if (seg == 2 && ph != 1)
					hold_off_asks <= hold_off_asks + 1;
				seg_end = item_count + SEGMENT_ITEMS;
				while (item_count < seg_end)
					random_sequence();
				settle();
				write_enable($urandom_range(0, 99) < 85);
			end
		end

		settle();
		if (mismatches == 0)
			$display("attack_decay_envelope: match");
		else
			$display("attack_decay_envelope: mismatch");
		$finish;
	end

endmodule
